@@ rtl/lcd_progress_bar_glyphs_unit_assert.svh @@
// ----------------------------------------------------------------------------
// lcd progress bar glyphs: assertion macros
// shared concurrent check forms, sampled on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LCD_PROGRESS_BAR_GLYPHS_UNIT_ASSERT_SVH
`define LCD_PROGRESS_BAR_GLYPHS_UNIT_ASSERT_SVH

// same-cycle implication
`define LPBG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lpbg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpbg_pkg
// types and constants shared by the progress bar glyph front, queue and back
// ----------------------------------------------------------------------------
`default_nettype none

package lpbg_pkg;

  localparam int unsigned PIX_W           = 8;   // saturated bar length in pixels
  localparam int unsigned LEN_W           = 6;   // bar length in characters
  localparam int unsigned VAL_W           = 8;   // progress and maximum
  localparam int unsigned NUM_W           = 16;  // progress * length * 6
  localparam int unsigned GLYPH_W         = 3;
  localparam int unsigned PIXELS_PER_CHAR = 6;

  localparam logic [GLYPH_W-1:0] EMPTY_GLYPH = 3'd0;
  localparam logic [GLYPH_W-1:0] FULL_GLYPH  = 3'd5;

  // one classified request handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [LEN_W-1:0] len;
    logic             err;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/lpbg_queue.sv @@
// ----------------------------------------------------------------------------
// lpbg_queue
// small job queue between the divide front and the glyph back
// ----------------------------------------------------------------------------
`default_nettype none

module lpbg_queue
  import lpbg_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic push,
  input  wire  job_t push_data,
  output logic       full,
  input  wire  logic pop,
  output job_t       pop_data,
  output logic       not_empty
);

  `include "lcd_progress_bar_glyphs_unit_assert.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // checks
  `LPBG_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue level over depth")
  `LPBG_ASSERT_NEXT(a_push_only_grows, do_push && !do_pop, count_r == $past(count_r) + 1'b1,
    "queue level did not grow on push")
  `LPBG_ASSERT_NEXT(a_pop_only_shrinks, do_pop && !do_push, count_r == $past(count_r) - 1'b1,
    "queue level did not shrink on pop")

endmodule

`default_nettype wire

@@ rtl/lpbg_front.sv @@
// ----------------------------------------------------------------------------
// lpbg_front
// takes a request, clamps the length and finds the pixel length with a
// bit-serial restoring divide, then queues the classified job; a zero-length request is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module lpbg_front
  import lpbg_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 40
) (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic             req_valid,
  output logic                   req_ready,
  input  wire  logic [VAL_W-1:0] progress,
  input  wire  logic [VAL_W-1:0] max_progress,
  input  wire  logic [LEN_W-1:0] bar_length,
  output logic                   push,
  output job_t                   push_data,
  input  wire  logic             full
);

  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned PROD_W = VAL_W + LEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

  state_t            state_r;
  logic [NUM_W-1:0]  quo_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  len_r;
  logic              err_r;

  logic [LEN_W-1:0]  len_sat;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic [VAL_W:0]    trial;
  logic              fits;
  logic [VAL_W:0]    diff;
  logic              accept;

  // clamp length and form progress * length * 6 as x*4 + x*2
  assign len_sat = (bar_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : bar_length;
  assign prod    = PROD_W'(progress) * PROD_W'(len_sat);
  assign num     = NUM_W'({prod, 2'b00}) + NUM_W'({prod, 1'b0});

  // one restoring divide step
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;

  // job out, quotient saturated to the pixel width
  assign push          = (state_r == S_PUSH);
  assign push_data.pix = (|quo_r[NUM_W-1:PIX_W]) ? '1 : quo_r[PIX_W-1:0];
  assign push_data.len = len_r;
  assign push_data.err = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            len_r <= len_sat;
            err_r <= (max_progress == '0);
            div_r <= max_progress;
            rem_r <= '0;
            cnt_r <= '0;
            if (len_sat == '0) begin
              state_r <= S_IDLE;
            end else if (max_progress == '0) begin
              quo_r   <= '0;
              state_r <= S_PUSH;
            end else begin
              quo_r   <= num;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpbg_back.sv @@
// ----------------------------------------------------------------------------
// lpbg_back
// takes queued jobs and emits one glyph beat per character cell
// ----------------------------------------------------------------------------
`default_nettype none

module lpbg_back
  import lpbg_pkg::*;
(
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  input  wire  logic               job_valid,
  input  wire  job_t               job,
  output logic                     pop,
  output logic                     out_valid,
  input  wire  logic               out_ready,
  output logic [GLYPH_W-1:0]       out_glyph,
  output logic                     out_last,
  output logic                     out_err
);

  `include "lcd_progress_bar_glyphs_unit_assert.svh"

  logic             busy_r;
  job_t             job_r;
  logic [LEN_W-1:0] idx_r;
  logic [PIX_W-1:0] start_r;
  logic             out_valid_r;
  logic [GLYPH_W-1:0] out_glyph_r;
  logic             out_last_r;
  logic             out_err_r;

  logic             load;
  logic             is_last;
  logic [PIX_W:0]   cell_end;
  logic [PIX_W-1:0] part;
  logic [GLYPH_W-1:0] glyph_nxt;

  assign pop  = !busy_r && job_valid;
  assign load = busy_r && (!out_valid_r || out_ready);

  assign is_last  = (idx_r + 1'b1 == job_r.len);
  assign cell_end = {1'b0, start_r} + (PIX_W + 1)'(FULL_GLYPH);
  assign part     = job_r.pix - start_r;

  // classify the current cell against the bar end
  always_comb begin
    priority if (job_r.err) begin
      glyph_nxt = EMPTY_GLYPH;
    end else if (cell_end <= {1'b0, job_r.pix}) begin
      glyph_nxt = FULL_GLYPH;
    end else if (start_r > job_r.pix) begin
      glyph_nxt = EMPTY_GLYPH;
    end else begin
      glyph_nxt = part[GLYPH_W-1:0];
    end
  end

  // cell walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r  <= 1'b1;
        job_r   <= job;
        idx_r   <= '0;
        start_r <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        out_glyph_r <= glyph_nxt;
        out_last_r  <= is_last;
        out_err_r   <= job_r.err;
        idx_r       <= idx_r + 1'b1;
        start_r     <= start_r + PIX_W'(PIXELS_PER_CHAR);
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_glyph = out_glyph_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  // checks
  `LPBG_ASSERT_NOW(a_err_empty, out_valid_r && out_err_r, out_glyph_r == EMPTY_GLYPH,
    "glyph not empty on a zero-maximum bar")
  `LPBG_ASSERT_NOW(a_glyph_range, out_valid_r, out_glyph_r <= FULL_GLYPH, "glyph code out of range")
  `LPBG_ASSERT_NEXT(a_last_ends_job, load && is_last, !busy_r && out_last_r,
    "job still running after its last cell")

endmodule

`default_nettype wire

@@ rtl/lcd_progress_bar_glyphs_unit.sv @@
// path: a request's first glyph beat follows the accept, the restoring divide steps (skipped
//   for a zero maximum), the queue push, the pop and the output register
// throughput: one glyph beat per cycle inside a bar while out_tready is high; a request's
//   divide overlaps the glyph walk of the bar before it through the job queue
// reset: synchronous active-low rst_n clears all control state; no memory clearing pass
// ----------------------------------------------------------------------------
// lcd_progress_bar_glyphs_unit
// character lcd bargraph: pixel length by exact divide, then one glyph per cell
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_progress_bar_glyphs_unit
  import lpbg_pkg::*;
#(
  parameter int unsigned MAX_LENGTH  = 40,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_tvalid,
  output logic              in_tready,
  input  wire  logic [23:0] in_tdata,   // progress[7:0], max_progress[15:8], bar_length[21:16]
  output logic              out_tvalid,
  input  wire  logic        out_tready,
  output logic [7:0]        out_tdata,  // glyph[2:0]
  output logic              out_tlast,
  output logic              out_tuser   // div_error[0]
);

  logic                q_push;
  job_t                q_push_data;
  logic                q_full;
  logic                q_pop;
  job_t                q_pop_data;
  logic                q_not_empty;
  logic [GLYPH_W-1:0]  glyph;

  // request intake and divide
  lpbg_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_tvalid),
    .req_ready    (in_tready),
    .progress     (in_tdata[7:0]),
    .max_progress (in_tdata[15:8]),
    .bar_length   (in_tdata[21:16]),
    .push         (q_push),
    .push_data    (q_push_data),
    .full         (q_full)
  );

  // job queue
  lpbg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // glyph emitter
  lpbg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (q_pop_data),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_glyph (glyph),
    .out_last  (out_tlast),
    .out_err   (out_tuser)
  );

  assign out_tdata = {(8 - GLYPH_W)'(0), glyph};

endmodule

`default_nettype wire
